[src/lz_match_tokenizer_top_assert.svh]
// Assertion macros for the tokenizer checker.
`ifndef LZ_MATCH_TOKENIZER_TOP_ASSERT_SVH
`define LZ_MATCH_TOKENIZER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LZT_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lz tokenizer check failed");
// Next-cycle implication checked outside reset.
`define LZT_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lz tokenizer check failed");
`endif

[src/lzt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzt_pkg
// Types and constants shared by the match tokenizer modules.
// ---------------------------------------------------------------------------
package lzt_pkg;
   localparam int BLOCK_BYTES_DEF = 4096;
   localparam int MAX_WINDOW_DEF  = 1024;
   localparam int SYM_W           = 11;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_MIN_DIST  = 3'd0,
      REG_MAX_DIST  = 3'd1,
      REG_MIN_LEN   = 3'd2,
      REG_SPLIT     = 3'd3,
      REG_DIST_FRST = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_CMP,
      ST_EVAL,
      ST_EMIT,
      ST_LIT
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             done_res;
   } rsp_type;

   typedef struct packed {
      logic [10:0] min_distance;
      logic [10:0] max_distance;
      logic [7:0]  min_length;
      logic        split_marker;
      logic        distance_first;
   } cfg_type;
endpackage

[src/lzt_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzt_store
// Block byte memory with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module lzt_store #(
   parameter int DEPTH = lzt_pkg::BLOCK_BYTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [7:0]    rd_data_a,
   output logic [7:0]    rd_data_b
);
   logic [7:0] mem [DEPTH];

   // Synchronous write and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[src/lzt_cfg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzt_cfg
// Configuration register file with the effective (clamped) values.
// ---------------------------------------------------------------------------
module lzt_cfg #(
   parameter int MAX_WINDOW = lzt_pkg::MAX_WINDOW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [10:0]      csr_wdata,
   output lzt_pkg::cfg_type cfg_eff
);
   lzt_pkg::cfg_type regs_ff;

   assign csr_ready = 1'b1;

   // Register writes by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.min_distance   <= 11'd1;
         regs_ff.max_distance   <= 11'd1024;
         regs_ff.min_length     <= 8'd2;
         regs_ff.split_marker   <= 1'b0;
         regs_ff.distance_first <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            lzt_pkg::REG_MIN_DIST:  regs_ff.min_distance   <= csr_wdata;
            lzt_pkg::REG_MAX_DIST:  regs_ff.max_distance   <= csr_wdata;
            lzt_pkg::REG_MIN_LEN:   regs_ff.min_length     <= csr_wdata[7:0];
            lzt_pkg::REG_SPLIT:     regs_ff.split_marker   <= csr_wdata[0];
            lzt_pkg::REG_DIST_FRST: regs_ff.distance_first <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp to legal working values.
   always_comb begin
      cfg_eff = regs_ff;
      if (regs_ff.min_distance == 11'd0) cfg_eff.min_distance = 11'd1;
      if ({21'd0, regs_ff.max_distance} > MAX_WINDOW)
         cfg_eff.max_distance = 11'(MAX_WINDOW);
      if (regs_ff.min_length < 8'd2) cfg_eff.min_length = 8'd2;
   end
endmodule

[src/lzt_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzt_engine
// Command sequencer: loads bytes, runs the distance/byte search loop
// against the block memory and emits the token symbols.
// ---------------------------------------------------------------------------
module lzt_engine #(
   parameter int BLOCK_BYTES = lzt_pkg::BLOCK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lzt_pkg::req_type req_item,
   input  lzt_pkg::cfg_type cfg,
   output logic             rsp_strobe,
   output lzt_pkg::rsp_type rsp_item
);
   localparam int AW = $clog2(BLOCK_BYTES);
   localparam int CW = $clog2(BLOCK_BYTES + 1);
   localparam int LW = 13;  // holds 257 + 1023

   lzt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, cursor_ff, cursor_in;
   logic [10:0]   dist_ff, dist_in, best_dist_ff, best_dist_in;
   logic [LW-1:0] len_ff, len_in, best_len_ff, best_len_in, lmax_ff, lmax_in;
   logic [1:0]    emit_ff, emit_in;
   logic          zero_ff, zero_in, pend_ff, pend_in;
   logic [LW-1:0] mod_ff, mod_in;
   logic          lit_ff, lit_in, lit_mode;
   lzt_pkg::rsp_type rsp_next;

   logic          wr_en;
   logic [AW-1:0] rd_a, rd_b;
   logic [7:0]    dat_a, dat_b;
   logic [CW+1:0] pos_l, ref_p;

   lzt_store #(.DEPTH(BLOCK_BYTES), .AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_item.data_byte), .rd_addr_a(rd_a), .rd_addr_b(rd_b),
      .rd_data_a(dat_a), .rd_data_b(dat_b)
   );

   assign busy  = (state_ff != lzt_pkg::ST_IDLE);
   assign wr_en = start && !busy && (req_item.cmd == lzt_pkg::CMD_LOAD)
                  && ({1'b0, count_ff} < (CW+1)'(BLOCK_BYTES));

   // Addresses: current byte i+l and the wrapped reference i+(l mod d)-d.
   assign pos_l = (CW+2)'(cursor_ff) + (CW+2)'(len_ff);
   assign ref_p = (CW+2)'(cursor_ff) + (CW+2)'(mod_ff) - (CW+2)'(dist_ff);
   assign rd_a  = pos_l[AW-1:0];
   assign rd_b  = ref_p[AW-1:0];

   // Next-state and datapath.
   always_comb begin
      state_in = state_ff; count_in = count_ff; cursor_in = cursor_ff;
      dist_in = dist_ff; len_in = len_ff; best_len_in = best_len_ff;
      best_dist_in = best_dist_ff; lmax_in = lmax_ff; emit_in = emit_ff;
      zero_in = zero_ff; pend_in = pend_ff; mod_in = mod_ff;
      unique case (state_ff)
         lzt_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_item.cmd)
                  lzt_pkg::CMD_LOAD:
                     if (wr_en) count_in = count_ff + CW'(1);
                  lzt_pkg::CMD_CLEAR: begin
                     count_in = '0; cursor_in = '0;
                  end
                  lzt_pkg::CMD_STEP: begin
                     best_dist_in = '0;
                     if (cursor_ff >= count_ff) state_in = lzt_pkg::ST_EMIT;
                     else begin
                        state_in = lzt_pkg::ST_DIST;
                        dist_in = cfg.min_distance;
                        best_len_in = LW'(cfg.min_length);
                        lmax_in = (cfg.distance_first && cfg.max_distance != 0) ?
                                  LW'(256) + LW'(cfg.max_distance) : LW'(257);
                     end
                     emit_in = 2'd0;
                  end
                  default: ;
               endcase
            end
         end
         lzt_pkg::ST_DIST: begin
            // Start comparing at one distance, or finish the search.
            len_in = '0; mod_in = '0; pend_in = 1'b0;
            if (dist_ff > cfg.max_distance) state_in = lzt_pkg::ST_EVAL;
            else state_in = lzt_pkg::ST_CMP;
         end
         lzt_pkg::ST_CMP: begin
            // pend marks that memory data for len_ff is valid this cycle.
            zero_in = (ref_p[CW+1]) || (pos_l >= (CW+2)'(count_ff));
            if (!pend_ff) begin
               if (len_ff >= lmax_ff || pos_l >= (CW+2)'(count_ff))
                  state_in = lzt_pkg::ST_EVAL;
               else begin
                  pend_in = 1'b1;
               end
               zero_in = ref_p[CW+1];
            end else begin
               pend_in = 1'b0;
               if ((zero_ff ? 8'd0 : dat_b) != dat_a) state_in = lzt_pkg::ST_EVAL;
               else begin
                  len_in = len_ff + LW'(1);
                  mod_in = (mod_ff + LW'(1) == LW'(dist_ff)) ? '0 : mod_ff + LW'(1);
               end
            end
         end
         lzt_pkg::ST_EVAL: begin
            if (dist_ff <= cfg.max_distance && len_ff > best_len_ff) begin
               best_len_in = len_ff; best_dist_in = dist_ff;
            end
            if (dist_ff > cfg.max_distance ||
                (len_ff > best_len_ff && (len_ff == lmax_ff || pos_l ==
                 (CW+2)'(count_ff))) || dist_ff == cfg.max_distance) begin
               state_in = (best_dist_in != 0) ? lzt_pkg::ST_EMIT : lzt_pkg::ST_LIT;
               len_in = '0;
            end else begin
               dist_in = dist_ff + 11'd1;
               state_in = lzt_pkg::ST_DIST;
            end
         end
         lzt_pkg::ST_LIT: state_in = lzt_pkg::ST_EMIT; // literal read pending
         lzt_pkg::ST_EMIT: begin
            emit_in = emit_ff + 2'd1;
            if (cursor_ff >= count_ff && best_dist_ff == 0 && emit_ff == 0 &&
                !lit_mode) state_in = lzt_pkg::ST_IDLE;
            else if (rsp_next.last) begin
               state_in = lzt_pkg::ST_IDLE;
               cursor_in = cursor_ff + (best_dist_ff != 0 ? CW'(best_len_ff) : CW'(1));
            end
         end
         default: state_in = lzt_pkg::ST_IDLE;
      endcase
   end

   // Literal flag: set while emitting a literal after a search.
   assign lit_mode = lit_ff;
   always_comb begin
      lit_in = lit_ff;
      if (state_ff == lzt_pkg::ST_LIT) lit_in = 1'b1;
      else if (state_ff == lzt_pkg::ST_IDLE) lit_in = 1'b0;
   end

   // Output symbol selection. A literal byte is the read at the cursor that
   // was issued in the literal cycle, so it is on dat_a while emitting.
   always_comb begin
      rsp_next = '0;
      if (lit_ff) begin
         rsp_next.symbol = 11'(dat_a) + 11'(cfg.split_marker);
         rsp_next.last = 1'b1;
      end else if (best_dist_ff == 0) begin
         rsp_next.done_res = 1'b1;
      end else if (cfg.split_marker) begin
         unique case (emit_ff)
            2'd0: rsp_next.symbol = '0;
            2'd1: rsp_next.symbol = best_dist_ff - 11'd1;
            default: begin
               rsp_next.symbol = 11'(best_len_ff - LW'(2)); rsp_next.last = 1'b1;
            end
         endcase
      end else if (cfg.distance_first) begin
         if (emit_ff == 2'd0) rsp_next.symbol = 11'd255 + best_dist_ff;
         else begin
            rsp_next.symbol = 11'(best_len_ff - LW'(2)); rsp_next.last = 1'b1;
         end
      end else begin
         if (emit_ff == 2'd0) rsp_next.symbol = 11'(LW'(254) + best_len_ff);
         else begin
            rsp_next.symbol = best_dist_ff - 11'd1; rsp_next.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzt_pkg::ST_IDLE; count_ff <= '0; cursor_ff <= '0;
         rsp_strobe <= 1'b0; lit_ff <= 1'b0; best_dist_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; cursor_ff <= cursor_in;
         rsp_strobe <= (state_ff == lzt_pkg::ST_EMIT); lit_ff <= lit_in;
         best_dist_ff <= best_dist_in;
      end
      rsp_item <= rsp_next;
      dist_ff <= dist_in; len_ff <= len_in; best_len_ff <= best_len_in;
      lmax_ff <= lmax_in; emit_ff <= emit_in; zero_ff <= zero_in;
      pend_ff <= pend_in; mod_ff <= mod_in;
   end
endmodule

[src/lz_match_tokenizer_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lz_match_tokenizer_top
// LZ77 match finder and tokenizer over one block of bytes.
// ---------------------------------------------------------------------------
// Usage: an item on req_item is taken at a rising edge with start high and
// busy low. A load writes one byte into the block memory unless it is full,
// a clear resets the byte count and cursor; both finish in the cycle they
// are taken and busy stays low, so they can follow back to back. A step
// raises busy and searches distances from min to max distance, stopping once
// a longer match reaches the length limit or the block end. Each distance
// has a setup state, a read and a compare per matching byte up to a
// mismatch, the length limit or the block end, and an evaluation state. A
// literal then has a read state and one emit state; a match has two or three
// emit states, one per symbol. Each symbol appears on rsp_item in the cycle
// after its emit state, marked by rsp_strobe for one cycle, on consecutive
// cycles. A step at the end of the block gives one done result. busy falls
// in the cycle that shows the last symbol, so the next item can be taken
// there. The receiver cannot stall. Configuration is written on the csr_
// channel, which is always ready, while the block is idle, a rule for the
// user that the block does not enforce. Reset clears the counts and the
// registers; the block memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module lz_match_tokenizer_top #(
   parameter int BLOCK_BYTES = lzt_pkg::BLOCK_BYTES_DEF,
   parameter int MAX_WINDOW  = lzt_pkg::MAX_WINDOW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lzt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output lzt_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [10:0]      csr_wdata
);
   lzt_pkg::cfg_type cfg;

   lzt_cfg #(.MAX_WINDOW(MAX_WINDOW)) u_cfg (
      .clock(clock), .reset(reset), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cfg_eff(cfg)
   );

   lzt_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .cfg(cfg), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );
endmodule

[src/lzt_checker.sv]
`timescale 1ns / 1ps
`include "lz_match_tokenizer_top_assert.svh"
// ---------------------------------------------------------------------------
// lzt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
module lzt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lzt_pkg::req_type req_item,
   input logic             rsp_strobe,
   input lzt_pkg::rsp_type rsp_item
);
   // A done result is never marked last.
   `LZT_ASSERT_IMP(a_done_not_last, clock, reset, rsp_strobe && rsp_item.done_res, !rsp_item.last)
   // Results other than a last symbol or a done result only appear while busy.
   `LZT_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_strobe && !rsp_item.last && !rsp_item.done_res, busy)
   // A load, clear or none command never raises busy.
   `LZT_ASSERT_NXT(a_load_short, clock, reset, start && !busy && req_item.cmd != lzt_pkg::CMD_STEP, !busy)
   // No result follows a load command directly.
   `LZT_ASSERT_NXT(a_load_quiet, clock, reset, start && !busy && req_item.cmd == lzt_pkg::CMD_LOAD, !rsp_strobe)
endmodule

bind lz_match_tokenizer_top lzt_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
);
